// File: hw/rtl/bsq_pkg.sv
// Package for the broadcast slot queue: shared constants, codes, command and
// configuration types. Used by every module of the block; depends on nothing.
`default_nettype none

package bsq_pkg;

   localparam int SLOTS_DEF       = 64;
   localparam int MAX_READERS_DEF = 8;
   localparam int WORD_BITS_DEF   = 64;
   localparam int SLOT_WORDS      = 7;
   localparam int QUEUE_DEPTH     = 2;

   localparam int STATUS_W        = 3;
   localparam int SLOTS_IN_USE_W  = 7;
   localparam int READER_COUNT_W  = 4;
   localparam int READER_ID_W     = 3;
   localparam int CSR_INDEX_W     = 1;
   localparam int CSR_DATA_W      = 7;
   // Width that holds any clamped reader count (up to 127).
   localparam int ACTIVE_W        = 7;

   localparam logic [SLOTS_IN_USE_W-1:0] SLOTS_IN_USE_RST = 7'd64;
   localparam logic [READER_COUNT_W-1:0] READER_COUNT_RST = 4'd1;

   typedef enum logic [CSR_INDEX_W-1:0] {
      CSR_SLOTS_IN_USE = 1'b0,
      CSR_READER_COUNT = 1'b1
   } csr_index_type;

   typedef enum logic [STATUS_W-1:0] {
      ST_OK         = 3'd0,
      ST_EMPTY      = 3'd1,
      ST_FULL       = 3'd2,
      ST_WAIT       = 3'd3,
      ST_BAD_READER = 3'd4
   } status_type;

   typedef enum logic [1:0] {
      KIND_WRITE      = 2'd0,
      KIND_READ       = 2'd1,
      KIND_BAD_READER = 2'd2
   } item_kind_type;

   typedef enum logic {
      BACK_EXEC  = 1'b0,
      BACK_FETCH = 1'b1
   } back_state_type;

   typedef struct packed {
      item_kind_type          kind;
      logic [READER_ID_W-1:0] reader_id;
   } cmd_type;

   typedef struct packed {
      logic [SLOTS_IN_USE_W-1:0] slots_in_use;
      logic [READER_COUNT_W-1:0] reader_count;
   } cfg_type;

   // Reader count clamped to the number of readers the block is built for.
   function automatic logic [ACTIVE_W-1:0] active_readers(
      input logic [READER_COUNT_W-1:0] count,
      input int                        max_readers
   );
      logic [ACTIVE_W-1:0] cnt_ext;
      logic [ACTIVE_W-1:0] max_ext;
      cnt_ext = ACTIVE_W'(count);
      max_ext = ACTIVE_W'(max_readers);
      return (cnt_ext > max_ext) ? max_ext : cnt_ext;
   endfunction

endpackage

`default_nettype wire

// File: hw/rtl/broadcast_slot_queue_top.sv
// A write, a bad-reader read or a read that ends in a status only passes
// through the command queue and is then executed into the response register;
// a read that returns a slot also passes the registered slot memory on the way.
// Throughput: one transfer per cycle while the response is not stalled, except
// a successful slot read, which also holds the back end for the slot memory read.
// Reset (synchronous): clears positions, done marks, queue and response
// register and restores the configuration defaults; the slot memory is kept.
`default_nettype none

module broadcast_slot_queue_top
   import bsq_pkg::*;
#(
   parameter int SLOTS       = SLOTS_DEF,
   parameter int MAX_READERS = MAX_READERS_DEF,
   parameter int WORD_BITS   = WORD_BITS_DEF,
   localparam int SW         = SLOT_WORDS * WORD_BITS,
   localparam int REQ_W      = ((READER_ID_W + SW + 7) / 8) * 8,
   localparam int RSP_W      = ((STATUS_W + SW + 7) / 8) * 8
) (
   input  wire logic                   clock,
   input  wire logic                   reset,
   // Request channel.
   input  wire logic                   req_tvalid,
   output      logic                   req_tready,
   // Fields from bit 0 up: reader_id (3), word0 .. word6 (WORD_BITS each).
   input  wire logic [REQ_W-1:0]       req_tdata,
   // Fields: operation (1): 0 write, 1 read.
   input  wire logic                   req_tuser,
   // Response channel.
   output      logic                   rsp_tvalid,
   input  wire logic                   rsp_tready,
   // Fields from bit 0 up: status (3), out_word0 .. out_word6 (WORD_BITS each).
   output      logic [RSP_W-1:0]       rsp_tdata,
   // Configuration write channel.
   input  wire logic                   csr_valid,
   output      logic                   csr_ready,
   input  wire logic [CSR_INDEX_W-1:0] csr_index,
   input  wire logic [CSR_DATA_W-1:0]  csr_data
);

   localparam int CMD_W = $bits(cmd_type);
   localparam int Q_W   = CMD_W + SW;

   cfg_type       cfg_ff;
   logic          q_full;
   logic          push;
   cmd_type       push_cmd;
   logic [SW-1:0] push_words;
   logic          q_valid;
   logic [Q_W-1:0] q_data;
   logic          q_pop;
   cmd_type       q_cmd;
   logic [SW-1:0] q_words;

   // Configuration registers take every transfer; an index that names no
   // register is accepted and ignored.
   assign csr_ready = 1'b1;

   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff.slots_in_use <= SLOTS_IN_USE_RST;
         cfg_ff.reader_count <= READER_COUNT_RST;
      end else if (csr_valid) begin
         case (csr_index_type'(csr_index))
            CSR_SLOTS_IN_USE: cfg_ff.slots_in_use <= csr_data[SLOTS_IN_USE_W-1:0];
            CSR_READER_COUNT: cfg_ff.reader_count <= csr_data[READER_COUNT_W-1:0];
            default: begin
               cfg_ff <= cfg_ff;
            end
         endcase
      end
   end

   // The front end decodes and classifies each request transfer.
   bsq_front #(
      .WORD_BITS   (WORD_BITS),
      .MAX_READERS (MAX_READERS)
   ) u_front (
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .req_tuser  (req_tuser),
      .cfg        (cfg_ff),
      .q_full     (q_full),
      .push       (push),
      .push_cmd   (push_cmd),
      .push_words (push_words)
   );

   // Commands wait here so that the front keeps accepting while the back end
   // is busy with a slot fetch or a stalled response.
   bsq_queue #(
      .DATA_W (Q_W),
      .DEPTH  (QUEUE_DEPTH)
   ) u_queue (
      .clock     (clock),
      .reset     (reset),
      .push      (push),
      .push_data ({push_cmd, push_words}),
      .full      (q_full),
      .pop       (q_pop),
      .q_valid   (q_valid),
      .q_data    (q_data)
   );

   assign q_cmd   = cmd_type'(q_data[Q_W-1 -: CMD_W]);
   assign q_words = q_data[SW-1:0];

   // The back end owns all queue state and the slot memory.
   bsq_back #(
      .SLOTS       (SLOTS),
      .MAX_READERS (MAX_READERS),
      .WORD_BITS   (WORD_BITS)
   ) u_back (
      .clock      (clock),
      .reset      (reset),
      .cfg        (cfg_ff),
      .q_valid    (q_valid),
      .q_cmd      (q_cmd),
      .q_words    (q_words),
      .q_pop      (q_pop),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata)
   );

endmodule

`default_nettype wire

// File: hw/rtl/bsq_front.sv
// Front end of the broadcast slot queue: decodes an incoming transfer and
// classifies it as write, read or bad-reader command. Depends on bsq_pkg.
`default_nettype none

module bsq_front
   import bsq_pkg::*;
#(
   parameter int WORD_BITS   = WORD_BITS_DEF,
   parameter int MAX_READERS = MAX_READERS_DEF,
   localparam int SW         = SLOT_WORDS * WORD_BITS,
   localparam int REQ_BITS   = READER_ID_W + SW,
   localparam int REQ_W      = ((REQ_BITS + 7) / 8) * 8
) (
   input  wire logic             req_tvalid,
   output      logic             req_tready,
   input  wire logic [REQ_W-1:0] req_tdata,
   input  wire logic             req_tuser,
   input  wire cfg_type          cfg,
   input  wire logic             q_full,
   output      logic             push,
   output      cmd_type          push_cmd,
   output      logic [SW-1:0]    push_words
);

   logic [READER_ID_W-1:0] rid;
   logic [ACTIVE_W-1:0]    active;

   assign rid        = req_tdata[READER_ID_W-1:0];
   assign active     = active_readers(cfg.reader_count, MAX_READERS);
   assign req_tready = !q_full;
   assign push       = req_tvalid && !q_full;
   assign push_words = req_tdata[READER_ID_W +: SW];

   // The user must change the reader count only while the block is idle; the
   // block does not enforce it. The check is done here, not at execution time.
   always_comb begin
      push_cmd.reader_id = rid;
      if (!req_tuser) begin
         push_cmd.kind = KIND_WRITE;
      end else if (ACTIVE_W'(rid) >= active) begin
         push_cmd.kind = KIND_BAD_READER;
      end else begin
         push_cmd.kind = KIND_READ;
      end
   end

endmodule

`default_nettype wire

// File: hw/rtl/bsq_queue.sv
// Short command queue between the front end and the back end of the
// broadcast slot queue. Depends on bsq_pkg for its default depth.
`default_nettype none

module bsq_queue
   import bsq_pkg::*;
#(
   parameter int DATA_W = 8,
   parameter int DEPTH  = QUEUE_DEPTH,
   localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1,
   localparam int CNT_W = $clog2(DEPTH + 1)
) (
   input  wire logic              clock,
   input  wire logic              reset,
   input  wire logic              push,
   input  wire logic [DATA_W-1:0] push_data,
   output      logic              full,
   input  wire logic              pop,
   output      logic              q_valid,
   output      logic [DATA_W-1:0] q_data
);

   logic [DATA_W-1:0] entry_ff [DEPTH];
   logic [PTR_W-1:0]  wr_ptr_ff, wr_ptr_in;
   logic [PTR_W-1:0]  rd_ptr_ff, rd_ptr_in;
   logic [CNT_W-1:0]  count_ff, count_in;
   logic              do_push, do_pop;

   assign full    = (count_ff == CNT_W'(DEPTH));
   assign q_valid = (count_ff != '0);
   assign q_data  = entry_ff[rd_ptr_ff];
   assign do_push = push && !full;
   assign do_pop  = pop && q_valid;

   always_comb begin
      wr_ptr_in = wr_ptr_ff;
      rd_ptr_in = rd_ptr_ff;
      count_in  = count_ff;
      if (do_push) begin
         wr_ptr_in = (wr_ptr_ff == PTR_W'(DEPTH - 1)) ? '0 : wr_ptr_ff + 1'b1;
      end
      if (do_pop) begin
         rd_ptr_in = (rd_ptr_ff == PTR_W'(DEPTH - 1)) ? '0 : rd_ptr_ff + 1'b1;
      end
      if (do_push && !do_pop) begin
         count_in = count_ff + 1'b1;
      end else if (do_pop && !do_push) begin
         count_in = count_ff - 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   always_ff @(posedge clock) begin
      if (do_push) begin
         entry_ff[wr_ptr_ff] <= push_data;
      end
   end

endmodule

`default_nettype wire

// File: hw/rtl/bsq_back.sv
// Back end of the broadcast slot queue: executes commands against the write
// and read positions, the done marks and the slot memory, and holds the
// response register. Depends on bsq_pkg.
`default_nettype none

module bsq_back
   import bsq_pkg::*;
#(
   parameter int SLOTS       = SLOTS_DEF,
   parameter int MAX_READERS = MAX_READERS_DEF,
   parameter int WORD_BITS   = WORD_BITS_DEF,
   localparam int SW         = SLOT_WORDS * WORD_BITS,
   localparam int RSP_BITS   = STATUS_W + SW,
   localparam int RSP_W      = ((RSP_BITS + 7) / 8) * 8
) (
   input  wire logic             clock,
   input  wire logic             reset,
   input  wire cfg_type          cfg,
   input  wire logic             q_valid,
   input  wire cmd_type          q_cmd,
   input  wire logic [SW-1:0]    q_words,
   output      logic             q_pop,
   output      logic             rsp_tvalid,
   input  wire logic             rsp_tready,
   output      logic [RSP_W-1:0] rsp_tdata
);

   localparam int PW = $clog2(SLOTS + 1);
   localparam int AW = $clog2(SLOTS);
   localparam int IW = (MAX_READERS > 1) ? $clog2(MAX_READERS) : 1;
   localparam int CW = (PW > SLOTS_IN_USE_W) ? PW : SLOTS_IN_USE_W;

   back_state_type       state_ff, state_in;
   logic [PW-1:0]        wp_ff, wp_in;
   logic [PW-1:0]        rpos_ff [MAX_READERS];
   logic [MAX_READERS-1:0] done_ff;
   logic [SW-1:0]        slot_mem [SLOTS];
   logic [SW-1:0]        mem_rdata_ff;
   logic                 rsp_valid_ff, rsp_valid_in;
   status_type           rsp_status_ff;
   logic [SW-1:0]        rsp_words_ff;

   logic [PW-1:0]          pass_len;
   logic [CW-1:0]          slots_ext;
   logic [ACTIVE_W-1:0]    active;
   logic [MAX_READERS-1:0] active_mask;
   logic                   all_done;
   logic [IW-1:0]          rid;
   logic [PW-1:0]          rp;
   logic [PW-1:0]          wr_slot;

   logic       ex_wrap;
   logic       ex_write;
   logic       ex_fetch;
   logic       ex_mark;
   status_type ex_status;

   logic go;
   logic out_free;
   logic mem_wr;
   logic mem_rd;
   logic out_load;
   logic out_from_mem;

   // Pass length: zero acts as one, anything above the slot count as the
   // slot count.
   assign slots_ext = CW'(cfg.slots_in_use);
   always_comb begin
      if (cfg.slots_in_use == '0) begin
         pass_len = PW'(1);
      end else if (slots_ext > CW'(SLOTS)) begin
         pass_len = PW'(SLOTS);
      end else begin
         pass_len = PW'(slots_ext);
      end
   end

   assign active = active_readers(cfg.reader_count, MAX_READERS);
   always_comb begin
      for (int i = 0; i < MAX_READERS; i++) begin
         active_mask[i] = (ACTIVE_W'(i) < active);
      end
   end
   assign all_done = &(done_ff | ~active_mask);

   assign rid     = IW'(q_cmd.reader_id);
   assign rp      = rpos_ff[rid];
   assign ex_wrap = (wp_ff >= pass_len);
   assign wr_slot = ex_wrap ? '0 : wp_ff;

   // Command evaluation against the current state.
   always_comb begin
      ex_status = ST_OK;
      ex_write  = 1'b0;
      ex_fetch  = 1'b0;
      ex_mark   = 1'b0;
      case (q_cmd.kind)
         KIND_WRITE: begin
            if (ex_wrap && !all_done) begin
               ex_status = ST_FULL;
            end else begin
               ex_write = 1'b1;
            end
         end
         KIND_READ: begin
            if (done_ff[rid]) begin
               ex_status = ST_WAIT;
            end else if (rp >= pass_len) begin
               ex_status = ST_WAIT;
               ex_mark   = 1'b1;
            end else if (rp == wp_ff) begin
               ex_status = ST_EMPTY;
            end else begin
               ex_fetch = 1'b1;
            end
         end
         default: begin
            ex_status = ST_BAD_READER;
         end
      endcase
   end

   assign out_free = !rsp_valid_ff || rsp_tready;

   // Next state.
   always_comb begin
      state_in = state_ff;
      case (state_ff)
         BACK_EXEC: begin
            if (q_valid && out_free && ex_fetch) begin
               state_in = BACK_FETCH;
            end
         end
         BACK_FETCH: begin
            state_in = BACK_EXEC;
         end
         default: begin
            state_in = BACK_EXEC;
         end
      endcase
   end

   // State machine outputs.
   always_comb begin
      go           = 1'b0;
      out_from_mem = 1'b0;
      case (state_ff)
         BACK_EXEC: begin
            go = q_valid && out_free;
         end
         BACK_FETCH: begin
            out_from_mem = 1'b1;
         end
         default: begin
            go = 1'b0;
         end
      endcase
   end

   assign q_pop    = go;
   assign mem_wr   = go && ex_write;
   assign mem_rd   = go && ex_fetch;
   assign out_load = (go && !ex_fetch) || out_from_mem;

   assign wp_in        = mem_wr ? (wr_slot + 1'b1) : wp_ff;
   assign rsp_valid_in = out_load || (rsp_valid_ff && !rsp_tready);

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= BACK_EXEC;
         wp_ff        <= '0;
         done_ff      <= '0;
         rsp_valid_ff <= 1'b0;
         for (int i = 0; i < MAX_READERS; i++) begin
            rpos_ff[i] <= '0;
         end
      end else begin
         state_ff     <= state_in;
         wp_ff        <= wp_in;
         rsp_valid_ff <= rsp_valid_in;
         if (mem_wr && ex_wrap) begin
            done_ff <= '0;
         end else if (go && ex_mark) begin
            done_ff[rid] <= 1'b1;
         end
         if (go && ex_mark) begin
            rpos_ff[rid] <= '0;
         end else if (mem_rd) begin
            rpos_ff[rid] <= rp + 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (mem_wr) begin
         slot_mem[wr_slot[AW-1:0]] <= q_words;
      end
      if (mem_rd) begin
         mem_rdata_ff <= slot_mem[rp[AW-1:0]];
      end
   end

   always_ff @(posedge clock) begin
      if (out_load) begin
         rsp_status_ff <= out_from_mem ? ST_OK : ex_status;
         rsp_words_ff  <= out_from_mem ? mem_rdata_ff : '0;
      end
   end

   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = RSP_W'({rsp_words_ff, rsp_status_ff});

   // The response register is always empty while a slot read is in flight.
   a_fetch_out_empty: assert property (@(posedge clock) disable iff (reset)
      (state_ff == BACK_FETCH) |-> !rsp_valid_ff)
      else $error("response register busy during slot fetch");

   // A slot read is always followed by the fetch cycle.
   a_fetch_follows: assert property (@(posedge clock) disable iff (reset)
      mem_rd |=> (state_ff == BACK_FETCH))
      else $error("slot read not followed by fetch");

   // The write position never runs past the slot count.
   a_wp_bound: assert property (@(posedge clock) disable iff (reset)
      wp_ff <= PW'(SLOTS))
      else $error("write position beyond slot count");

   // A reader that finishes its pass is rewound; this checks that a done mark is set.
   a_mark_rewinds: assert property (@(posedge clock) disable iff (reset)
      (go && ex_mark) |=> (done_ff != '0))
      else $error("done mark not set after pass end");

endmodule

`default_nettype wire
